### design/rct_pkg.sv
package rct_pkg;

   localparam int OFF_W      = 48;
   localparam int LEN_W      = 32;
   localparam int ULEN_W     = 33;
   localparam int END_W      = 49;
   localparam int GRP_W      = 8;
   localparam int SUM_W      = 42;
   localparam int HS_W       = 21;
   localparam int PCT_W      = 7;
   localparam int CNT_OUT_W  = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;
   localparam int PROD_W     = SUM_W + PCT_W;

   localparam logic [SUM_W-1:0]  SUM_MAX         = '1;
   localparam logic [HS_W-1:0]   HEAD_SKIP_RESET = HS_W'(128 * 1024);
   localparam logic [PCT_W-1:0]  LIMIT_RESET     = PCT_W'(50);
   localparam logic [ULEN_W-1:0] CHECKSUM_BYTES  = ULEN_W'(8);
   localparam logic [PCT_W-1:0]  PERCENT         = PCT_W'(100);

   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_SKIP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MERGE     = 2'd2;

   localparam logic [1:0] VERDICT_GO     = 2'd0;
   localparam logic [1:0] VERDICT_REPEAT = 2'd1;
   localparam logic [1:0] VERDICT_LIMIT  = 2'd2;

   typedef enum logic [1:0] {
      CMD_CLEAR_ALL  = 2'd0,
      CMD_LOAD       = 2'd1,
      CMD_CHUNK      = 2'd2,
      CMD_CLEAR_SEEN = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [OFF_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
      logic [GRP_W-1:0]  group;
      logic              has_checksum;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [1:0]           verdict;
      logic [SUM_W-1:0]     asked_bytes;
      logic [SUM_W-1:0]     total_bytes;
      logic [CNT_OUT_W-1:0] seen_count;
      logic [CNT_OUT_W-1:0] request_groups;
      logic                 table_overflow;
      logic                 chunk_overflow;
   } rsp_type;

   // classified work handed from front to back
   typedef struct packed {
      cmd_type           kind;
      logic [OFF_W-1:0]  off;
      logic [ULEN_W-1:0] len;
      logic [GRP_W-1:0]  grp;
      logic [END_W-1:0]  cend;
      logic              store;
      logic              last;
   } entry_type;

   typedef struct packed {
      logic [OFF_W-1:0]  off;
      logic [ULEN_W-1:0] len;
      logic [GRP_W-1:0]  grp;
   } unit_type;

   typedef struct packed {
      logic [OFF_W-1:0] cstart;
      logic [END_W-1:0] cend;
   } chunk_type;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE,
      S_LS_RD, S_LS_CK, S_LSH_RD, S_LSH_WR, S_LPUT, S_GB_RD, S_GB_WR,
      S_CS_RD, S_CS_CK, S_CSH_RD, S_CSH_WR, S_CPUT,
      S_EV_CLR, S_M_RD, S_M_CK, S_W_SRD, S_W_SCK, S_K_RD, S_K_CK,
      S_P_RD, S_P_CK, S_Q_RD, S_Q_CK, S_MUL, S_VERD
   } back_state_type;

   function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

endpackage

### design/rct_ram.sv
module rct_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 16,
     parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1)
   (input  logic             clock,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/rct_front.sv
module rct_front
   import rct_pkg::*;
   (input  logic            clock,
    input  logic            reset,
    input  logic            start,
    input  req_type         req_item,
    input  logic [HS_W-1:0] head_skip,
    input  logic            hold,
    input  logic            pop,
    output logic            busy,
    output logic            head_valid,
    output entry_type       head);

   entry_type  q_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   entry_type  ent;
   logic       keep, push;
   logic [OFF_W-1:0] clip_a;
   logic [END_W-1:0] clip_b;

   // clip the chunk below head skip; drop empty work
   always_comb begin
      clip_a = (req_item.offset > OFF_W'(head_skip)) ? req_item.offset : OFF_W'(head_skip);
      clip_b = {1'b0, req_item.offset} + END_W'(req_item.length);
      ent.kind  = req_item.cmd;
      ent.grp   = req_item.group;
      ent.last  = req_item.last;
      ent.cend  = clip_b;
      ent.off   = req_item.offset;
      ent.len   = ULEN_W'(req_item.length) +
                  (req_item.has_checksum ? CHECKSUM_BYTES : '0);
      ent.store = 1'b1;
      keep      = 1'b1;
      case (req_item.cmd)
         CMD_LOAD: begin
            keep = (req_item.length != '0);
         end
         CMD_CHUNK: begin
            ent.off   = clip_a;
            ent.store = (req_item.length != '0) && ({1'b0, clip_a} < clip_b);
            keep      = ent.store || req_item.last;
         end
         default: begin
            keep = 1'b1;
         end
      endcase
   end

   assign busy       = (cnt_ff == 2'd2) || hold;
   assign push       = start && !busy && keep;
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = q_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= ent;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (pop) begin
            rp_ff <= !rp_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule

### design/rct_back.sv
module rct_back
   import rct_pkg::*;
   #(parameter int MAX_UNITS  = 1024,
     parameter int MAX_GROUPS = 256,
     parameter int MAX_CHUNKS = 64)
   (input  logic             clock,
    input  logic             reset,
    input  logic             head_valid,
    input  entry_type        head,
    input  logic [PCT_W-1:0] limit_percent,
    input  logic             merge_same_offset,
    output logic             pop,
    output logic             clearing,
    output logic             rsp_strobe,
    output rsp_type          rsp_item);

   localparam int UAW = $clog2(MAX_UNITS);
   localparam int UCW = $clog2(MAX_UNITS + 1);
   localparam int CAW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int CCW = $clog2(MAX_CHUNKS + 1);
   localparam int GAW = $clog2(MAX_GROUPS);
   localparam int GCW = $clog2(MAX_GROUPS + 1);

   back_state_type state_ff, state_in;
   entry_type cur_ff, cur_in;
   logic [UCW-1:0] ucount_ff, ucount_in, uptr_ff, uptr_in, sp_ff, sp_in;
   logic [CCW-1:0] ccount_ff, ccount_in, cptr_ff, cptr_in, csh_ff, csh_in;
   logic [GCW-1:0] gptr_ff, gptr_in, nreq_ff, nreq_in, nseen_ff, nseen_in;
   logic [SUM_W-1:0] total_ff, total_in, asked_ff, asked_in;
   logic tflag_ff, tflag_in, cflag_ff, cflag_in, grew_ff, grew_in, fin_ff, fin_in;
   logic [MAX_GROUPS-1:0] seen_ff, seen_in, now_ff, now_in;
   logic [OFF_W-1:0] ra_ff, ra_in, na_ff, na_in;
   logic [END_W-1:0] rb_ff, rb_in, nb_ff, nb_in;
   logic [PROD_W-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_ff, rsp_in;

   // memory ports
   logic u_we, u_re, c_we, c_re, v_we, v_re, g_we, g_re;
   logic [UAW-1:0] u_wa, u_ra, v_wa, v_ra;
   logic [CAW-1:0] c_wa, c_ra;
   logic [GAW-1:0] g_wa, g_ra;
   unit_type  u_wd, u_rd;
   chunk_type c_wd, c_rd;
   logic [ULEN_W-1:0] v_wd, v_rd;
   logic [SUM_W-1:0]  g_wd, g_rd;

   // shared conditions
   logic u_full, c_full, uptr_lt, sp_lt, walk_done, ev_go, p_hit;
   logic [UCW-1:0] sp_dec, k_start;
   logic [CCW-1:0] csh_dec;
   logic [END_W-1:0] u_end, hi;
   logic [OFF_W-1:0] lo;
   logic [END_W-1:0] span;
   logic [31:0] cur_g32, u_g32;
   logic [GAW-1:0] cur_gidx, u_gidx, q_gidx;
   logic cur_gok, u_gok, seen_now;

   assign u_full   = ucount_ff >= UCW'(MAX_UNITS);
   assign c_full   = ccount_ff >= CCW'(MAX_CHUNKS);
   assign uptr_lt  = uptr_ff < ucount_ff;
   assign sp_lt    = sp_ff < ucount_ff;
   assign sp_dec   = sp_ff - UCW'(1);
   assign csh_dec  = csh_ff - CCW'(1);
   assign k_start  = (sp_ff != '0) ? sp_dec : '0;
   assign u_end    = {1'b0, u_rd.off} + END_W'(u_rd.len);
   assign hi       = (rb_ff < u_end) ? rb_ff : u_end;
   assign lo       = (ra_ff > u_rd.off) ? ra_ff : u_rd.off;
   assign span     = hi - {1'b0, lo};
   assign cur_g32  = {{(32-GRP_W){1'b0}}, cur_ff.grp};
   assign u_g32    = {{(32-GRP_W){1'b0}}, u_rd.grp};
   assign cur_gidx = cur_g32[GAW-1:0];
   assign u_gidx   = u_g32[GAW-1:0];
   assign q_gidx   = gptr_ff[GAW-1:0];
   assign cur_gok  = cur_g32 < 32'(MAX_GROUPS);
   assign u_gok    = u_g32 < 32'(MAX_GROUPS);
   assign walk_done = ((state_ff == S_K_RD) && !uptr_lt) ||
                      ((state_ff == S_K_CK) && ({1'b0, u_rd.off} >= rb_ff));
   assign p_hit    = (v_rd != '0) && ({v_rd, 1'b0} >= {1'b0, u_rd.len}) &&
                     u_gok && !now_ff[u_gidx];
   assign seen_now = seen_ff[q_gidx] || ((nreq_ff != '0) && now_ff[q_gidx]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLR: begin
            if (gptr_ff == GCW'(MAX_GROUPS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (head_valid) begin
               case (head.kind)
                  CMD_CLEAR_ALL: state_in = S_CLR;
                  CMD_LOAD:      state_in = S_LS_RD;
                  CMD_CHUNK: begin
                     if (head.store && !c_full) begin
                        state_in = S_CS_RD;
                     end else if (head.last) begin
                        state_in = S_EV_CLR;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_LS_RD:  state_in = uptr_lt ? S_LS_CK : (u_full ? S_IDLE : S_LSH_RD);
         S_LS_CK: begin
            if (u_rd.off <= cur_ff.off) begin
               state_in = ((u_rd.off == cur_ff.off) && merge_same_offset) ? S_IDLE : S_LS_RD;
            end else begin
               state_in = u_full ? S_IDLE : S_LSH_RD;
            end
         end
         S_LSH_RD: state_in = (sp_ff > uptr_ff) ? S_LSH_WR : S_LPUT;
         S_LSH_WR: state_in = S_LSH_RD;
         S_LPUT:   state_in = cur_gok ? S_GB_RD : S_IDLE;
         S_GB_RD:  state_in = S_GB_WR;
         S_GB_WR:  state_in = S_IDLE;
         S_CS_RD:  state_in = (cptr_ff < ccount_ff) ? S_CS_CK : S_CSH_RD;
         S_CS_CK:  state_in = (c_rd.cstart <= cur_ff.off) ? S_CS_RD : S_CSH_RD;
         S_CSH_RD: state_in = (csh_ff > cptr_ff) ? S_CSH_WR : S_CPUT;
         S_CSH_WR: state_in = S_CSH_RD;
         S_CPUT:   state_in = cur_ff.last ? S_EV_CLR : S_IDLE;
         S_EV_CLR: begin
            if (!uptr_lt) begin
               state_in = ((ucount_ff != '0) && (ccount_ff != '0)) ? S_M_RD : S_P_RD;
            end
         end
         S_M_RD:   state_in = (cptr_ff < ccount_ff) ? S_M_CK : S_W_SRD;
         S_M_CK: begin
            if ((cptr_ff == '0) || (c_rd.cstart <= rb_ff[OFF_W-1:0] && !rb_ff[END_W-1])
                || rb_ff[END_W-1]) begin
               state_in = S_M_RD;
            end else begin
               state_in = S_W_SRD;
            end
         end
         S_W_SRD:  state_in = sp_lt ? S_W_SCK : S_K_RD;
         S_W_SCK:  state_in = (u_rd.off <= ra_ff) ? S_W_SRD : S_K_RD;
         S_K_RD:   state_in = walk_done ? (fin_ff ? S_P_RD : S_M_RD) : S_K_CK;
         S_K_CK:   state_in = walk_done ? (fin_ff ? S_P_RD : S_M_RD) : S_K_RD;
         S_P_RD:   state_in = uptr_lt ? S_P_CK : S_Q_RD;
         S_P_CK:   state_in = S_P_RD;
         S_Q_RD:   state_in = (gptr_ff < GCW'(MAX_GROUPS)) ? S_Q_CK : S_MUL;
         S_Q_CK:   state_in = S_Q_RD;
         S_MUL:    state_in = S_VERD;
         S_VERD:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cur_in = cur_ff;  ucount_in = ucount_ff;  uptr_in = uptr_ff;  sp_in = sp_ff;
      ccount_in = ccount_ff;  cptr_in = cptr_ff;  csh_in = csh_ff;
      gptr_in = gptr_ff;  nreq_in = nreq_ff;  nseen_in = nseen_ff;
      total_in = total_ff;  asked_in = asked_ff;  tflag_in = tflag_ff;
      cflag_in = cflag_ff;  grew_in = grew_ff;  fin_in = fin_ff;
      seen_in = seen_ff;  now_in = now_ff;
      ra_in = ra_ff;  rb_in = rb_ff;  na_in = na_ff;  nb_in = nb_ff;
      p1_in = p1_ff;  p2_in = p2_ff;  rsp_in = rsp_ff;  rsp_strobe_in = 1'b0;
      pop = 1'b0;  ev_go = 1'b0;
      u_we = 1'b0;  u_re = 1'b0;  u_wa = uptr_ff[UAW-1:0];  u_ra = uptr_ff[UAW-1:0];
      u_wd = u_rd;
      c_we = 1'b0;  c_re = 1'b0;  c_wa = cptr_ff[CAW-1:0];  c_ra = cptr_ff[CAW-1:0];
      c_wd = c_rd;
      v_we = 1'b0;  v_re = 1'b0;  v_wa = uptr_ff[UAW-1:0];  v_ra = uptr_ff[UAW-1:0];
      v_wd = '0;
      g_we = 1'b0;  g_re = 1'b0;  g_wa = q_gidx;  g_ra = q_gidx;  g_wd = '0;

      case (state_ff)
         S_CLR: begin
            g_we    = 1'b1;
            gptr_in = gptr_ff + GCW'(1);
         end
         S_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cur_in = head;
               case (head.kind)
                  CMD_CLEAR_ALL: begin
                     ucount_in = '0;  ccount_in = '0;  total_in = '0;  seen_in = '0;
                     tflag_in = 1'b0;  cflag_in = 1'b0;  gptr_in = '0;
                  end
                  CMD_LOAD: begin
                     uptr_in = '0;
                  end
                  CMD_CHUNK: begin
                     cptr_in = '0;
                     if (head.store && c_full) begin
                        cflag_in = 1'b1;
                     end
                     ev_go = !(head.store && !c_full) && head.last;
                  end
                  default: begin
                     seen_in = '0;
                  end
               endcase
            end
         end
         S_LS_RD: begin
            u_re = uptr_lt;
            sp_in = ucount_ff;
            if (!uptr_lt && u_full) begin
               tflag_in = 1'b1;
            end
         end
         S_LS_CK: begin
            sp_in = ucount_ff;
            if (u_rd.off <= cur_ff.off) begin
               uptr_in = uptr_ff + UCW'(1);
            end else if (u_full) begin
               tflag_in = 1'b1;
            end
         end
         S_LSH_RD: begin
            u_re = 1'b1;
            u_ra = sp_dec[UAW-1:0];
         end
         S_LSH_WR: begin
            u_we  = 1'b1;
            u_wa  = sp_ff[UAW-1:0];
            u_wd  = u_rd;
            sp_in = sp_dec;
         end
         S_LPUT: begin
            u_we      = 1'b1;
            u_wd.off  = cur_ff.off;
            u_wd.len  = cur_ff.len;
            u_wd.grp  = cur_ff.grp;
            ucount_in = ucount_ff + UCW'(1);
            total_in  = add_sat(total_ff, SUM_W'(cur_ff.len));
         end
         S_GB_RD: begin
            g_re = 1'b1;
            g_ra = cur_gidx;
         end
         S_GB_WR: begin
            g_we = 1'b1;
            g_wa = cur_gidx;
            g_wd = add_sat(g_rd, SUM_W'(cur_ff.len));
         end
         S_CS_RD: begin
            c_re   = (cptr_ff < ccount_ff);
            csh_in = ccount_ff;
         end
         S_CS_CK: begin
            csh_in = ccount_ff;
            if (c_rd.cstart <= cur_ff.off) begin
               cptr_in = cptr_ff + CCW'(1);
            end
         end
         S_CSH_RD: begin
            c_re = 1'b1;
            c_ra = csh_dec[CAW-1:0];
         end
         S_CSH_WR: begin
            c_we   = 1'b1;
            c_wa   = csh_ff[CAW-1:0];
            c_wd   = c_rd;
            csh_in = csh_dec;
         end
         S_CPUT: begin
            c_we        = 1'b1;
            c_wd.cstart = cur_ff.off;
            c_wd.cend   = cur_ff.cend;
            ccount_in   = ccount_ff + CCW'(1);
            ev_go       = cur_ff.last;
         end
         S_EV_CLR: begin
            if (uptr_lt) begin
               v_we    = 1'b1;
               uptr_in = uptr_ff + UCW'(1);
            end else begin
               uptr_in = '0;
               cptr_in = '0;
               fin_in  = 1'b0;
            end
         end
         S_M_RD: begin
            c_re = (cptr_ff < ccount_ff);
            if (cptr_ff >= ccount_ff) begin
               fin_in = 1'b1;
            end
         end
         S_M_CK: begin
            if (cptr_ff == '0) begin
               ra_in   = c_rd.cstart;
               rb_in   = c_rd.cend;
               cptr_in = CCW'(1);
            end else if ({1'b0, c_rd.cstart} <= rb_ff) begin
               if (c_rd.cend > rb_ff) begin
                  rb_in = c_rd.cend;
               end
               cptr_in = cptr_ff + CCW'(1);
            end else begin
               na_in = c_rd.cstart;
               nb_in = c_rd.cend;
            end
         end
         S_W_SRD: begin
            u_re = sp_lt;
            u_ra = sp_ff[UAW-1:0];
            if (!sp_lt) begin
               uptr_in = k_start;
            end
         end
         S_W_SCK: begin
            if (u_rd.off <= ra_ff) begin
               sp_in = sp_ff + UCW'(1);
            end else begin
               uptr_in = k_start;
            end
         end
         S_K_RD: begin
            u_re = uptr_lt;
            v_re = uptr_lt;
         end
         S_K_CK: begin
            if (!walk_done) begin
               if (u_end > {1'b0, ra_ff}) begin
                  v_we = 1'b1;
                  v_wd = v_rd + span[ULEN_W-1:0];
               end
               uptr_in = uptr_ff + UCW'(1);
            end
         end
         S_P_RD: begin
            u_re = uptr_lt;
            v_re = uptr_lt;
            if (!uptr_lt) begin
               gptr_in  = '0;
               grew_in  = 1'b0;
               asked_in = '0;
               nseen_in = '0;
            end
         end
         S_P_CK: begin
            if (p_hit) begin
               now_in[u_gidx] = 1'b1;
               nreq_in        = nreq_ff + GCW'(1);
            end
            uptr_in = uptr_ff + UCW'(1);
         end
         S_Q_RD: begin
            g_re = (gptr_ff < GCW'(MAX_GROUPS));
         end
         S_Q_CK: begin
            seen_in[q_gidx] = seen_now;
            if (seen_now && !seen_ff[q_gidx]) begin
               grew_in = 1'b1;
            end
            if (seen_now) begin
               asked_in = add_sat(asked_ff, g_rd);
               nseen_in = nseen_ff + GCW'(1);
            end
            gptr_in = gptr_ff + GCW'(1);
         end
         S_MUL: begin
            p1_in = PROD_W'(asked_ff) * PROD_W'(PERCENT);
            p2_in = PROD_W'(limit_percent) * PROD_W'(total_ff);
         end
         S_VERD: begin
            rsp_strobe_in = 1'b1;
            rsp_in.verdict = VERDICT_GO;
            if (nreq_ff != '0) begin
               if ((total_ff != '0) && (p1_ff > p2_ff)) begin
                  rsp_in.verdict = VERDICT_LIMIT;
               end else if ((nreq_ff >= GCW'(2)) && !grew_ff) begin
                  rsp_in.verdict = VERDICT_REPEAT;
               end
            end
            rsp_in.asked_bytes    = asked_ff;
            rsp_in.total_bytes    = total_ff;
            rsp_in.seen_count     = CNT_OUT_W'(nseen_ff);
            rsp_in.request_groups = CNT_OUT_W'(nreq_ff);
            rsp_in.table_overflow = tflag_ff;
            rsp_in.chunk_overflow = cflag_ff;
            ccount_in = '0;
            cflag_in  = 1'b0;
         end
         default: begin
            pop = 1'b0;
         end
      endcase

      // advance to the next merged range once a walk ends
      if (walk_done && !fin_ff) begin
         ra_in   = na_ff;
         rb_in   = nb_ff;
         cptr_in = cptr_ff + CCW'(1);
      end
      if (walk_done && fin_ff) begin
         uptr_in = '0;
      end
      if (ev_go) begin
         uptr_in = '0;
         sp_in   = '0;
         now_in  = '0;
         nreq_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;  uptr_ff <= uptr_in;  sp_ff <= sp_in;  cptr_ff <= cptr_in;
      csh_ff <= csh_in;  nreq_ff <= nreq_in;  nseen_ff <= nseen_in;  asked_ff <= asked_in;
      grew_ff <= grew_in;  fin_ff <= fin_in;  now_ff <= now_in;
      ra_ff <= ra_in;  rb_ff <= rb_in;  na_ff <= na_in;  nb_ff <= nb_in;
      p1_ff <= p1_in;  p2_ff <= p2_in;  rsp_ff <= rsp_in;
      if (reset) begin
         state_ff      <= S_CLR;
         gptr_ff       <= '0;
         ucount_ff     <= '0;
         ccount_ff     <= '0;
         total_ff      <= '0;
         tflag_ff      <= 1'b0;
         cflag_ff      <= 1'b0;
         seen_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gptr_ff       <= gptr_in;
         ucount_ff     <= ucount_in;
         ccount_ff     <= ccount_in;
         total_ff      <= total_in;
         tflag_ff      <= tflag_in;
         cflag_ff      <= cflag_in;
         seen_ff       <= seen_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign clearing   = (state_ff == S_CLR);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   rct_ram #(.WIDTH($bits(unit_type)), .DEPTH(MAX_UNITS), .AW(UAW)) u_unit_ram (
      .clock(clock), .wr_en(u_we), .wr_addr(u_wa), .wr_data(u_wd),
      .rd_en(u_re), .rd_addr(u_ra), .rd_data(u_rd));

   rct_ram #(.WIDTH(ULEN_W), .DEPTH(MAX_UNITS), .AW(UAW)) u_cover_ram (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_en(v_re), .rd_addr(v_ra), .rd_data(v_rd));

   rct_ram #(.WIDTH($bits(chunk_type)), .DEPTH(MAX_CHUNKS), .AW(CAW)) u_chunk_ram (
      .clock(clock), .wr_en(c_we), .wr_addr(c_wa), .wr_data(c_wd),
      .rd_en(c_re), .rd_addr(c_ra), .rd_data(c_rd));

   rct_ram #(.WIDTH(SUM_W), .DEPTH(MAX_GROUPS), .AW(GAW)) u_group_ram (
      .clock(clock), .wr_en(g_we), .wr_addr(g_wa), .wr_data(g_wd),
      .rd_en(g_re), .rd_addr(g_ra), .rd_data(g_rd));

endmodule

### design/read_coverage_tracker_core.sv
// channel   ports                          handshake
// request   start, busy, req_item          beat taken when start && !busy
// result    rsp_strobe, rsp_item           one-cycle strobe, no back-pressure
// config    csr_we, csr_index, csr_wdata   write when csr_we, no wait
//
// One item at a time is carried out by the back sequencer; a two-deep queue
// in front takes items while it works. A load scans the table for its place
// and shifts the entries above it up; a chunk does the same over the chunk
// buffer. The final chunk runs the evaluation: a clear pass, the range merge,
// the range start search, the walk over the table, the classify pass over the
// table and a pass over the group sums. Reset and clear-all sweep the group
// sum RAM with busy high. The receiver cannot stall: each result is shown for
// one cycle.
module read_coverage_tracker_core
   import rct_pkg::*;
   #(parameter int MAX_UNITS  = 1024,
     parameter int MAX_GROUPS = 256,
     parameter int MAX_CHUNKS = 64)
   (input  logic                  clock,
    input  logic                  reset,
    input  logic                  start,
    output logic                  busy,
    input  req_type               req_item,
    output logic                  rsp_strobe,
    output rsp_type               rsp_item,
    input  logic                  csr_we,
    input  logic [CSR_IDX_W-1:0]  csr_index,
    input  logic [CSR_DATA_W-1:0] csr_wdata);

   // configuration registers
   logic [HS_W-1:0]  head_skip_ff, head_skip_in;
   logic [PCT_W-1:0] limit_ff, limit_in;
   logic             merge_ff, merge_in;

   // front to back
   logic      head_valid, pop, clearing;
   entry_type head;

   // decode the write; drop indexes beyond the register list
   always_comb begin
      head_skip_in = head_skip_ff;
      limit_in     = limit_ff;
      merge_in     = merge_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HEAD_SKIP: head_skip_in = csr_wdata[HS_W-1:0];
            CSR_LIMIT:     limit_in     = csr_wdata[PCT_W-1:0];
            CSR_MERGE:     merge_in     = csr_wdata[0];
            default:       merge_in     = merge_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_skip_ff <= HEAD_SKIP_RESET;
         limit_ff     <= LIMIT_RESET;
         merge_ff     <= 1'b1;
      end else begin
         head_skip_ff <= head_skip_in;
         limit_ff     <= limit_in;
         merge_ff     <= merge_in;
      end
   end

   // classify, clip and queue incoming beats
   rct_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_item(req_item),
      .head_skip(head_skip_ff), .hold(clearing), .pop(pop),
      .busy(busy), .head_valid(head_valid), .head(head));

   // table insertion, chunk sorting and the coverage evaluation
   rct_back #(.MAX_UNITS(MAX_UNITS), .MAX_GROUPS(MAX_GROUPS), .MAX_CHUNKS(MAX_CHUNKS))
   u_back (
      .clock(clock), .reset(reset), .head_valid(head_valid), .head(head),
      .limit_percent(limit_ff), .merge_same_offset(merge_ff),
      .pop(pop), .clearing(clearing), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item));

endmodule
